/* hw/rtl/rpss_pkg.sv */
// Shared types and constants for the random pair shuffle selector.
package rpss_pkg;

   localparam int POP_MAX_DEFAULT = 256;
   localparam int CNT_W           = 9;
   localparam int WORD_W          = 32;
   localparam int OUT_IDX_W       = 8;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [CNT_W-1:0]     incoming_count;
      logic [CNT_W-1:0]     destination_count;
      logic [CNT_W-1:0]     max_migrations;
      logic [WORD_W-1:0]    rand_incoming;
      logic [WORD_W-1:0]    rand_destination;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] destination_index;
      logic [OUT_IDX_W-1:0] incoming_index;
      logic                 last;
   } rsp_type;

endpackage

/* hw/rtl/rpss_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module rpss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rpss_mod_unit.sv */
// Iterative remainder unit: 32-bit word modulo a 9-bit divisor, two bits a cycle.
module rpss_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [rpss_pkg::WORD_W-1:0]  dividend,
   input  logic [rpss_pkg::CNT_W-1:0]   divisor,
   output logic                         done,
   output logic [rpss_pkg::CNT_W-1:0]   remainder
);

   localparam int ITER  = rpss_pkg::WORD_W / 2;
   localparam int ITR_W = $clog2(ITER);

   logic                         active_ff, active_in;
   logic                         done_ff, done_in;
   logic [ITR_W-1:0]             cnt_ff, cnt_in;
   logic [rpss_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [rpss_pkg::CNT_W-1:0]   div_ff, div_in;
   logic [rpss_pkg::CNT_W-1:0]   rem_ff, rem_in;

   logic [rpss_pkg::CNT_W:0]     r1, r2;
   logic [rpss_pkg::CNT_W-1:0]   t1, t2;

   // two restoring steps per cycle
   always_comb begin
      r1 = {rem_ff, word_ff[rpss_pkg::WORD_W-1]};
      if (r1 >= {1'b0, div_ff}) begin
         r1 = r1 - {1'b0, div_ff};
      end
      t1 = r1[rpss_pkg::CNT_W-1:0];
      r2 = {t1, word_ff[rpss_pkg::WORD_W-2]};
      if (r2 >= {1'b0, div_ff}) begin
         r2 = r2 - {1'b0, div_ff};
      end
      t2 = r2[rpss_pkg::CNT_W-1:0];
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      word_in   = word_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      if (go) begin
         active_in = 1'b1;
         cnt_in    = '0;
         word_in   = dividend;
         div_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         rem_in  = t2;
         word_in = word_ff << 2;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ITR_W'(ITER - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      word_ff <= word_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/rpss_perm.sv */
// Permutation store: RAM plus written marks; an unwritten entry reads as its index.
module rpss_perm #(
   parameter int POP_MAX = rpss_pkg::POP_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic [$clog2(POP_MAX)-1:0] rd_addr,
   input  logic                       wr_en,
   input  logic [$clog2(POP_MAX)-1:0] wr_addr,
   input  logic [$clog2(POP_MAX)-1:0] wr_data,
   output logic [$clog2(POP_MAX)-1:0] rd_value
);

   localparam int IDX_W = $clog2(POP_MAX);

   logic [POP_MAX-1:0] mark_ff, mark_in;
   logic               mark_rd_ff;
   logic [IDX_W-1:0]   rd_addr_ff;
   logic [IDX_W-1:0]   ram_q;

   rpss_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POP_MAX)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      mark_in = mark_ff;
      if (clear) begin
         mark_in = '0;
      end else if (wr_en) begin
         mark_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff    <= '0;
         mark_rd_ff <= 1'b0;
      end else begin
         mark_ff    <= mark_in;
         mark_rd_ff <= mark_ff[rd_addr];
      end
      rd_addr_ff <= rd_addr;
   end

   assign rd_value = mark_rd_ff ? ram_q : rd_addr_ff;

endmodule

/* hw/rtl/random_pair_shuffle_selector.sv */
// Random pair shuffle selector: partial shuffle of two identity permutations.
// A draw item is accepted only while idle; busy stays high until its result is given,
// so a new draw waits for the last: the shared 2-bit-a-cycle remainder unit runs two
// modulos per draw, then the RAM access states S_RD_A, S_RD_B, S_WR_A and S_WR_B follow.
// A start item is taken without raising busy and clears the written marks at once.
// Reset leaves the block idle with no run and all marks clear; results cannot be stalled.
module random_pair_shuffle_selector #(
   parameter int POP_MAX = rpss_pkg::POP_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rpss_pkg::req_type req_item,
   output logic              rsp_strobe,
   output rpss_pkg::rsp_type rsp_item
);

   localparam int IDX_W = $clog2(POP_MAX);
   localparam int CNT_W = rpss_pkg::CNT_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MOD_INC = 3'd1;
   localparam logic [2:0] S_MOD_DST = 3'd2;
   localparam logic [2:0] S_RD_A    = 3'd3;
   localparam logic [2:0] S_RD_B    = 3'd4;
   localparam logic [2:0] S_WR_A    = 3'd5;
   localparam logic [2:0] S_WR_B    = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic             run_active_ff, run_active_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [CNT_W-1:0] slot_total_ff, slot_total_in;
   logic [rpss_pkg::WORD_W-1:0] rand_dst_ff, rand_dst_in;
   logic [IDX_W-1:0] j_inc_ff, j_inc_in;
   logic [IDX_W-1:0] j_dst_ff, j_dst_in;
   logic [IDX_W-1:0] a_inc_ff, a_inc_in, a_dst_ff, a_dst_in;
   logic [IDX_W-1:0] b_inc_ff, b_inc_in, b_dst_ff, b_dst_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rpss_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic [CNT_W-1:0] sat_inc, sat_dst, sat_lim, len;
   logic             draw_ok;
   logic [IDX_W-1:0] pos_idx;
   logic [CNT_W-1:0] j_sum;

   logic                        mod_go;
   logic [rpss_pkg::WORD_W-1:0] mod_dividend;
   logic [CNT_W-1:0]            mod_divisor;
   logic                        mod_done;
   logic [CNT_W-1:0]            mod_rem;

   logic             perm_clear;
   logic [IDX_W-1:0] inc_rd_addr, dst_rd_addr;
   logic             perm_wr_en;
   logic [IDX_W-1:0] inc_wr_addr, inc_wr_data, dst_wr_addr, dst_wr_data;
   logic [IDX_W-1:0] inc_value, dst_value;

   assign accept  = start && !busy;
   assign pos_idx = IDX_W'(pos_ff);
   assign j_sum   = CNT_W'(pos_ff + mod_rem);

   // saturate counts to the population size
   assign sat_inc = (32'(req_item.incoming_count) > POP_MAX) ?
                    CNT_W'(POP_MAX) : req_item.incoming_count;
   assign sat_dst = (32'(req_item.destination_count) > POP_MAX) ?
                    CNT_W'(POP_MAX) : req_item.destination_count;
   assign sat_lim = (32'(req_item.max_migrations) > POP_MAX) ?
                    CNT_W'(POP_MAX) : req_item.max_migrations;

   always_comb begin
      len = sat_lim;
      if (sat_inc < len) begin
         len = sat_inc;
      end
      if (sat_dst < len) begin
         len = sat_dst;
      end
   end

   assign draw_ok = run_active_ff && (pos_ff < run_len_ff) && (run_len_ff <= slot_total_ff);

   rpss_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (mod_go),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   rpss_perm #(
      .POP_MAX (POP_MAX)
   ) u_perm_inc (
      .clock    (clock),
      .reset    (reset),
      .clear    (perm_clear),
      .rd_addr  (inc_rd_addr),
      .wr_en    (perm_wr_en),
      .wr_addr  (inc_wr_addr),
      .wr_data  (inc_wr_data),
      .rd_value (inc_value)
   );

   rpss_perm #(
      .POP_MAX (POP_MAX)
   ) u_perm_dst (
      .clock    (clock),
      .reset    (reset),
      .clear    (perm_clear),
      .rd_addr  (dst_rd_addr),
      .wr_en    (perm_wr_en),
      .wr_addr  (dst_wr_addr),
      .wr_data  (dst_wr_data),
      .rd_value (dst_value)
   );

   always_comb begin
      state_in      = state_ff;
      run_active_in = run_active_ff;
      pos_in        = pos_ff;
      run_len_in    = run_len_ff;
      slot_total_in = slot_total_ff;
      rand_dst_in   = rand_dst_ff;
      j_inc_in      = j_inc_ff;
      j_dst_in      = j_dst_ff;
      a_inc_in      = a_inc_ff;
      a_dst_in      = a_dst_ff;
      b_inc_in      = b_inc_ff;
      b_dst_in      = b_dst_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mod_go        = 1'b0;
      mod_dividend  = req_item.rand_incoming;
      mod_divisor   = run_len_ff - pos_ff;
      perm_clear    = 1'b0;
      inc_rd_addr   = pos_idx;
      dst_rd_addr   = pos_idx;
      perm_wr_en    = 1'b0;
      inc_wr_addr   = pos_idx;
      dst_wr_addr   = pos_idx;
      inc_wr_data   = inc_value;
      dst_wr_data   = dst_value;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.operation == rpss_pkg::OP_START) begin
                  perm_clear    = 1'b1;
                  pos_in        = '0;
                  run_len_in    = len;
                  slot_total_in = sat_dst;
                  run_active_in = (len != '0);
               end else if (draw_ok) begin
                  mod_go      = 1'b1;
                  rand_dst_in = req_item.rand_destination;
                  state_in    = S_MOD_INC;
               end else begin
                  // drop the draw, no run to serve
                  run_active_in = 1'b0;
               end
            end
         end
         S_MOD_INC: begin
            mod_dividend = rand_dst_ff;
            mod_divisor  = slot_total_ff - pos_ff;
            if (mod_done) begin
               j_inc_in = IDX_W'(j_sum);
               mod_go   = 1'b1;
               state_in = S_MOD_DST;
            end
         end
         S_MOD_DST: begin
            if (mod_done) begin
               j_dst_in = IDX_W'(j_sum);
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            state_in = S_RD_B;
         end
         S_RD_B: begin
            inc_rd_addr = j_inc_ff;
            dst_rd_addr = j_dst_ff;
            a_inc_in    = inc_value;
            a_dst_in    = dst_value;
            state_in    = S_WR_A;
         end
         S_WR_A: begin
            perm_wr_en = 1'b1;
            b_inc_in   = inc_value;
            b_dst_in   = dst_value;
            state_in   = S_WR_B;
         end
         S_WR_B: begin
            perm_wr_en  = 1'b1;
            inc_wr_addr = j_inc_ff;
            dst_wr_addr = j_dst_ff;
            inc_wr_data = a_inc_ff;
            dst_wr_data = a_dst_ff;
            rsp_strobe_in            = 1'b1;
            rsp_in.destination_index = rpss_pkg::OUT_IDX_W'(b_dst_ff);
            rsp_in.incoming_index    = rpss_pkg::OUT_IDX_W'(b_inc_ff);
            rsp_in.last              = (CNT_W'(pos_ff + 1'b1) == run_len_ff);
            pos_in = CNT_W'(pos_ff + 1'b1);
            if (CNT_W'(pos_ff + 1'b1) == run_len_ff) begin
               run_active_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_active_ff <= 1'b0;
         pos_ff        <= '0;
         run_len_ff    <= '0;
         slot_total_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_active_ff <= run_active_in;
         pos_ff        <= pos_in;
         run_len_ff    <= run_len_in;
         slot_total_ff <= slot_total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rand_dst_ff <= rand_dst_in;
      j_inc_ff    <= j_inc_in;
      j_dst_ff    <= j_dst_in;
      a_inc_ff    <= a_inc_in;
      a_dst_ff    <= a_dst_in;
      b_inc_ff    <= b_inc_in;
      b_dst_ff    <= b_dst_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == S_WR_B) && !busy)
      else $error("result strobe without a completed write-back");

   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      busy |-> run_active_ff)
      else $error("sequencer busy outside an active run");

   a_start_one_cycle: assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.operation == rpss_pkg::OP_START) |=> !busy && !rsp_strobe)
      else $error("start item did not complete in one cycle");

endmodule

/* bench/random_pair_shuffle_selector_tb.sv */
// Self-checking bench for the random pair shuffle selector: table, random runs, shadow shuffle.
module random_pair_shuffle_selector_tb;

   localparam int          POP         = rpss_pkg::POP_MAX_DEFAULT;
   localparam int          CNT_W       = rpss_pkg::CNT_W;
   localparam int          ITEM_TARGET = 1250;
   localparam int          CALM_FROM   = ITEM_TARGET - 150;
   localparam int          TAIL_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int          INC_SIDE    = 0;
   localparam int          DST_SIDE    = 1;

   typedef struct packed {
      rpss_pkg::req_type item;
      logic              typed;
      logic              has_pair;
      rpss_pkg::rsp_type pair;
   } step_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   rpss_pkg::req_type req_item = '0;
   logic              rsp_strobe;
   rpss_pkg::rsp_type rsp_item;

   // shadow copy of the shuffle state
   logic [7:0]     perm_mem [2][POP];
   logic [POP-1:0] perm_mark [2];
   int unsigned    step_pos = 0;
   int unsigned    run_len  = 0;
   int unsigned    slot_tot = 0;
   bit             run_on   = 1'b0;

   rpss_pkg::rsp_type pending_pairs [$];
   step_row_type      plan [$];
   rpss_pkg::rsp_type want;
   int                fail_count  = 0;
   int                sent_items  = 0;
   int unsigned       cycle_count = 0;

   random_pair_shuffle_selector i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned sat_count(input logic [CNT_W-1:0] v);
      return (v > POP) ? POP : v;
   endfunction

   // one Fisher-Yates step: swap entries pos and j, hand back the new entry at pos
   function automatic logic [7:0] swap_step(input int side, input int unsigned pos,
                                            input int unsigned n, input logic [31:0] word);
      int unsigned j;
      logic [7:0]  a;
      logic [7:0]  b;
      j = pos + word % (n - pos);
      a = perm_mark[side][pos] ? perm_mem[side][pos] : 8'(pos);
      b = perm_mark[side][j] ? perm_mem[side][j] : 8'(j);
      perm_mem[side][pos] = b;
      perm_mark[side][pos] = 1'b1;
      perm_mem[side][j] = a;
      perm_mark[side][j] = 1'b1;
      return b;
   endfunction

   function automatic bit predict_pair(input rpss_pkg::req_type r,
                                       output rpss_pkg::rsp_type pair);
      int unsigned inc;
      int unsigned dst;
      int unsigned len;
      pair = '0;
      if (r.operation == rpss_pkg::OP_START) begin
         inc = sat_count(r.incoming_count);
         dst = sat_count(r.destination_count);
         len = sat_count(r.max_migrations);
         if (inc < len) len = inc;
         if (dst < len) len = dst;
         perm_mark[INC_SIDE] = '0;
         perm_mark[DST_SIDE] = '0;
         step_pos = 0;
         run_len  = len;
         slot_tot = dst;
         run_on   = (len != 0);
         return 1'b0;
      end
      if (!run_on || step_pos >= run_len || run_len > slot_tot) begin
         run_on = 1'b0;
         return 1'b0;
      end
      pair.incoming_index    = swap_step(INC_SIDE, step_pos, run_len, r.rand_incoming);
      pair.destination_index = swap_step(DST_SIDE, step_pos, slot_tot, r.rand_destination);
      pair.last              = (step_pos + 1 == run_len);
      step_pos++;
      if (pair.last) run_on = 1'b0;
      return 1'b1;
   endfunction

   function automatic step_row_type mk_row(input logic op, input int inc, input int dst,
                                           input int lim, input logic [31:0] ri,
                                           input logic [31:0] rd, input bit typed,
                                           input bit has, input int d, input int i,
                                           input bit l);
      step_row_type s;
      s.item.operation         = op;
      s.item.incoming_count    = inc[CNT_W-1:0];
      s.item.destination_count = dst[CNT_W-1:0];
      s.item.max_migrations    = lim[CNT_W-1:0];
      s.item.rand_incoming     = ri;
      s.item.rand_destination  = rd;
      s.typed                  = typed;
      s.has_pair               = has;
      s.pair.destination_index = d[7:0];
      s.pair.incoming_index    = i[7:0];
      s.pair.last              = l;
      return s;
   endfunction

   function automatic void add_row(input step_row_type s);
      plan = {plan, s};
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic rpss_pkg::req_type make_draw();
      rpss_pkg::req_type r;
      r.operation         = rpss_pkg::OP_DRAW;
      r.incoming_count    = CNT_W'($urandom_range(0, 511));
      r.destination_count = CNT_W'($urandom_range(0, 511));
      r.max_migrations    = CNT_W'($urandom_range(0, 511));
      r.rand_incoming     = rand_word();
      r.rand_destination  = rand_word();
      return r;
   endfunction

   function automatic rpss_pkg::req_type make_start();
      rpss_pkg::req_type r;
      r = make_draw();
      r.operation = rpss_pkg::OP_START;
      case ($urandom_range(0, 19))
         0: ;  // full range, saturation included
         1: begin
            r.incoming_count    = CNT_W'($urandom_range(0, 12));
            r.destination_count = CNT_W'($urandom_range(0, 12));
            r.max_migrations    = CNT_W'($urandom_range(0, 12));
            case ($urandom_range(0, 2))
               0:       r.incoming_count    = '0;
               1:       r.destination_count = '0;
               default: r.max_migrations    = '0;
            endcase
         end
         2: begin
            r.incoming_count    = CNT_W'($urandom_range(200, 511));
            r.destination_count = CNT_W'($urandom_range(200, 511));
            r.max_migrations    = CNT_W'($urandom_range(1, 8));
         end
         default: begin
            r.incoming_count    = CNT_W'($urandom_range(1, 12));
            r.destination_count = CNT_W'($urandom_range(1, 16));
            r.max_migrations    = CNT_W'($urandom_range(1, 12));
         end
      endcase
      return r;
   endfunction

   task automatic idle_burst();
      start <= 1'b0;
      if ($urandom_range(0, 1)) begin
         // let the block finish first so the gap lands on the busy-to-idle boundary
         @(posedge clock);
         while (busy) @(posedge clock);
      end
      repeat ($urandom_range(1, 4)) @(posedge clock);
   endtask

   task automatic drain_pairs();
      start <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() != 0) @(posedge clock);
   endtask

   // present one item, hold until accepted, then record what it should produce
   task automatic send_item(input rpss_pkg::req_type r, input bit typed, input bit has_pair,
                            input rpss_pkg::rsp_type pair);
      rpss_pkg::rsp_type guess;
      bit                got;
      if (sent_items < CALM_FROM && $urandom_range(0, 5) == 0) idle_burst();
      req_item <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = predict_pair(r, guess);
      if (typed) begin
         if (has_pair) pending_pairs = {pending_pairs, pair};
      end else if (got) begin
         pending_pairs = {pending_pairs, guess};
      end
      if (r.operation == rpss_pkg::OP_START || got) sent_items++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected result: destination_index %0d incoming_index %0d last %0d",
                   rsp_item.destination_index, rsp_item.incoming_index, rsp_item.last);
            fail_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_item.destination_index !== want.destination_index) begin
               $error("destination_index: expected %0d, actual %0d",
                      want.destination_index, rsp_item.destination_index);
               fail_count++;
            end
            if (rsp_item.incoming_index !== want.incoming_index) begin
               $error("incoming_index: expected %0d, actual %0d",
                      want.incoming_index, rsp_item.incoming_index);
               fail_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_item.last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("random_pair_shuffle_selector_tb NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned draws;
      bit          drained_mid;
      drained_mid = 1'b0;

      // draw while idle, empty runs, single pair, saturation, restart, tiny ranges
      add_row(mk_row(rpss_pkg::OP_DRAW, 511, 511, 511, '1, '1, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 0, 5, 5, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 3, 0, 3, '1, '1, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 511, 511, 511, '1, '1, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 1, 1, 1, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '1, '1, 1, 1, 0, 0, 1));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '1, '1, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 511, 511, 511, '1, '1, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '0, '0, 1, 1, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '1, '1, 0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 2, 256, 300, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'h89AB_CDEF, 32'h1234_5678,
                     0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'hFEDC_BA98, 32'h0765_4321,
                     0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 256, 2, 256, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'd1, 32'd1, 1, 1, 1, 1, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '0, '0, 1, 1, 0, 0, 1));
      add_row(mk_row(rpss_pkg::OP_START, 256, 256, 3, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                     0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA,
                     0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555,
                     0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, '1, '1, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_START, 5, 400, 2, '0, '0, 1, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'hDEAD_BEEF, 32'hFFFF_FF00,
                     0, 0, 0, 0, 0));
      add_row(mk_row(rpss_pkg::OP_DRAW, 0, 0, 0, 32'h0000_00FF, 32'hCAFE_F00D,
                     0, 0, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].has_pair,
                                  plan[k].pair);
      drain_pairs();

      while (sent_items < ITEM_TARGET) begin
         if (!drained_mid && sent_items >= ITEM_TARGET / 2) begin
            drain_pairs();
            drained_mid = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) send_item(make_draw(), 0, 0, '0);
         send_item(make_start(), 0, 0, '0);
         draws = run_on ? run_len : 0;
         case ($urandom_range(0, 7))
            0: if (draws > 0) draws = $urandom_range(0, draws - 1);  // abandon early
            1: draws = draws + $urandom_range(1, 2);                 // overrun the end
            default: ;
         endcase
         repeat (draws) send_item(make_draw(), 0, 0, '0);
      end

      drain_pairs();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("random_pair_shuffle_selector_tb OK");
      end else begin
         $display("random_pair_shuffle_selector_tb NOT OK");
      end
      $finish;
   end

endmodule
